FILE: rtl/core/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg
// Shared constants, codes and types of the tap tempo estimator.
// ----------------------------------------------------------------------------
package tte_pkg;

	localparam int TIME_BITS_DEF = 32;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int TPM_BITS      = 16;
	localparam int BPM_BITS      = 10;
	localparam int QUO_BPM_BITS  = 16;
	localparam int IN_DATA_BITS  = 32;
	localparam int OUT_DATA_BITS = 16;

	localparam logic [QUO_BPM_BITS-1:0] BPM_NUMERATOR = 16'd60000;
	localparam logic [TPM_BITS-1:0]     DIV_BY_THREE  = 16'd3;

	localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RST  = 32'd10000;
	localparam logic [CFG_DATA_BITS-1:0] TOLERANCE_RST = 32'd10000;
	localparam logic [TPM_BITS-1:0]      TPM_RST       = 16'd100;
	localparam logic [BPM_BITS-1:0]      MIN_BPM_RST   = 10'd30;
	localparam logic [BPM_BITS-1:0]      MAX_BPM_RST   = 10'd300;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_DEBOUNCE,
		CFG_TOLERANCE,
		CFG_TPM,
		CFG_MIN_BPM,
		CFG_MAX_BPM
	} tte_cfg_idx_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV3,
		BK_DIVT,
		BK_DIVB,
		BK_OUT
	} tte_back_state_t;

	typedef struct packed {
		logic go;
		logic accepted;
	} tte_job_flags_t;

	typedef struct packed {
		logic                start;
		logic [TPM_BITS-1:0] divisor;
	} tte_div_req_t;

endpackage

FILE: rtl/core/tte_queue.sv
// ----------------------------------------------------------------------------
// tte_queue
// Two-entry job queue between the press front end and the tempo back end.
// ----------------------------------------------------------------------------
module tte_queue import tte_pkg::*; #(
	parameter int WIDTH = TIME_BITS_DEF + 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign rdata = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= wdata;
	end

endmodule

FILE: rtl/core/tte_front.sv
// ----------------------------------------------------------------------------
// tte_front
// Press front end: debounce, interval ring update, match check, job push.
// ----------------------------------------------------------------------------
module tte_front import tte_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [IN_DATA_BITS-1:0]  in_time,
	input  logic [CFG_DATA_BITS-1:0] debounce,
	input  logic [CFG_DATA_BITS-1:0] tolerance,
	input  logic                     tpm_nonzero,
	input  logic                     full,
	output logic                     push,
	output tte_job_flags_t           push_flags,
	output logic [TIME_BITS+1:0]     push_sum
);

	localparam int SUM_BITS = TIME_BITS + 2;
	localparam int CMP_BITS = (TIME_BITS > CFG_DATA_BITS) ? TIME_BITS : CFG_DATA_BITS;

	function automatic logic [TIME_BITS-1:0] abs_diff(input logic [TIME_BITS-1:0] a,
			input logic [TIME_BITS-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	logic [TIME_BITS-1:0] now_s1;
	logic                 v_s1;
	logic                 acc_s2;
	logic                 v_s2;
	logic [TIME_BITS-1:0] last_q;
	logic [TIME_BITS-1:0] ring_q [3];
	logic [1:0]           pos_q;
	logic                 seen_q;

	logic [TIME_BITS-1:0] interval;
	logic                 acc;
	logic [1:0]           pos_next;
	logic                 match;

	assign in_ready = !v_s1 && !v_s2;
	assign interval = now_s1 - last_q;
	assign acc      = !(seen_q && (CMP_BITS'(interval) < CMP_BITS'(debounce)));
	assign pos_next = (pos_q == 2'd2) ? 2'd0 : pos_q + 2'd1;

	assign match = (CMP_BITS'(abs_diff(ring_q[0], ring_q[1])) <= CMP_BITS'(tolerance)) &&
		(CMP_BITS'(abs_diff(ring_q[1], ring_q[2])) <= CMP_BITS'(tolerance)) &&
		(CMP_BITS'(abs_diff(ring_q[0], ring_q[2])) <= CMP_BITS'(tolerance));

	assign push                = v_s2 && !full;
	assign push_flags.accepted = acc_s2;
	assign push_flags.go       = acc_s2 && match && tpm_nonzero;
	assign push_sum            = SUM_BITS'(ring_q[0]) + SUM_BITS'(ring_q[1]) +
		SUM_BITS'(ring_q[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			last_q    <= '0;
			ring_q[0] <= '0;
			ring_q[1] <= '0;
			ring_q[2] <= '0;
			pos_q     <= 2'd0;
			seen_q    <= 1'b0;
		end else begin
			v_s1 <= in_valid && in_ready;
			if (v_s1) begin
				v_s2 <= 1'b1;
				if (acc) begin
					seen_q           <= 1'b1;
					pos_q            <= pos_next;
					ring_q[pos_next] <= interval;
					last_q           <= now_s1;
				end
			end else if (push) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			now_s1 <= TIME_BITS'(in_time);
		if (v_s1)
			acc_s2 <= acc;
	end

endmodule

FILE: rtl/core/tte_divider.sv
// ----------------------------------------------------------------------------
// tte_divider
// Shared restoring divider, two quotient bits per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
module tte_divider import tte_pkg::*; #(
	parameter int QW = TIME_BITS_DEF + 2,
	parameter int CW = $clog2(QW / 2 + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tte_div_req_t  req,
	input  logic [QW-1:0] dividend,
	input  logic [CW-1:0] cycles,
	output logic          done,
	output logic [QW-1:0] quotient
);

	logic [QW-1:0]       dq_q;
	logic [TPM_BITS-1:0] rem_q;
	logic [TPM_BITS-1:0] divisor_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [QW-1:0]       dq_n;
	logic [TPM_BITS-1:0] rem_n;

	always_comb begin
		logic [TPM_BITS:0] trial;
		dq_n  = dq_q;
		rem_n = rem_q;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_n, dq_n[QW-1]};
			dq_n  = dq_n << 1;
			if (trial >= {1'b0, divisor_q}) begin
				rem_n   = TPM_BITS'(trial - {1'b0, divisor_q});
				dq_n[0] = 1'b1;
			end else begin
				rem_n = trial[TPM_BITS-1:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1)) && !req.start;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cycles;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q      <= dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			dq_q  <= dq_n;
			rem_q <= rem_n;
		end
	end

endmodule

FILE: rtl/core/tte_back.sv
// ----------------------------------------------------------------------------
// tte_back
// Tempo back end: averages, converts to bpm on the shared divider, range check.
// ----------------------------------------------------------------------------
module tte_back import tte_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  tte_job_flags_t       q_flags,
	input  logic [TIME_BITS+1:0] q_sum,
	output logic                 q_pop,
	input  logic [TPM_BITS-1:0]  tpm,
	input  logic [BPM_BITS-1:0]  min_bpm,
	input  logic [BPM_BITS-1:0]  max_bpm,
	output logic                 out_tvalid,
	input  logic                 out_tready,
	output logic                 out_accepted,
	output logic                 out_tempo_valid,
	output logic [BPM_BITS-1:0]  out_tempo_bpm
);

	localparam int SUM_BITS = TIME_BITS + 2;
	localparam int QW       = ((SUM_BITS + 1) / 2) * 2;
	localparam int CW       = $clog2(QW / 2 + 1);

	tte_back_state_t state_q;
	tte_back_state_t state_d;

	tte_div_req_t        div_req;
	logic [QW-1:0]       div_dividend;
	logic [CW-1:0]       div_cycles;
	logic                div_done;
	logic [QW-1:0]       div_quo;

	logic                acc_q;
	logic                res_valid_q;
	logic [BPM_BITS-1:0] res_bpm_q;
	logic                m_tvalid_q;
	logic                m_acc_q;
	logic                m_valid_q;
	logic [BPM_BITS-1:0] m_bpm_q;

	logic                    ms_zero;
	logic [TPM_BITS-1:0]     ms_sat;
	logic [QUO_BPM_BITS-1:0] bpm16;
	logic                    in_range;
	logic                    res_load;
	logic                    out_load;

	tte_divider #(
		.QW (QW),
		.CW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.cycles   (div_cycles),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign ms_zero  = (div_quo == '0);
	assign ms_sat   = (|div_quo[QW-1:TPM_BITS]) ? '1 : div_quo[TPM_BITS-1:0];
	assign bpm16    = div_quo[QUO_BPM_BITS-1:0];
	assign in_range = (bpm16 >= QUO_BPM_BITS'(min_bpm)) && (bpm16 <= QUO_BPM_BITS'(max_bpm));

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty)
					state_d = q_flags.go ? BK_DIV3 : BK_OUT;
			end
			BK_DIV3: begin
				if (div_done)
					state_d = BK_DIVT;
			end
			BK_DIVT: begin
				if (div_done)
					state_d = ms_zero ? BK_OUT : BK_DIVB;
			end
			BK_DIVB: begin
				if (div_done)
					state_d = BK_OUT;
			end
			BK_OUT: begin
				if (!m_tvalid_q || out_tready)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop         = 1'b0;
		div_req.start = 1'b0;
		div_req.divisor = DIV_BY_THREE;
		div_dividend  = QW'(q_sum);
		div_cycles    = CW'(QW / 2);
		res_load      = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_pop         = !q_empty;
				div_req.start = !q_empty && q_flags.go;
			end
			BK_DIV3: begin
				div_req.start   = div_done;
				div_req.divisor = tpm;
				div_dividend    = div_quo;
			end
			BK_DIVT: begin
				div_req.start   = div_done && !ms_zero;
				div_req.divisor = ms_sat;
				div_dividend    = {BPM_NUMERATOR, {(QW - QUO_BPM_BITS){1'b0}}};
				div_cycles      = CW'(QUO_BPM_BITS / 2);
			end
			BK_DIVB: begin
				res_load = div_done;
			end
			BK_OUT: begin
				out_load = !m_tvalid_q || out_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (out_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			acc_q       <= q_flags.accepted;
			res_valid_q <= 1'b0;
			res_bpm_q   <= '0;
		end else if (res_load) begin
			res_valid_q <= in_range;
			res_bpm_q   <= in_range ? bpm16[BPM_BITS-1:0] : '0;
		end
		if (out_load) begin
			m_acc_q   <= acc_q;
			m_valid_q <= res_valid_q;
			m_bpm_q   <= res_bpm_q;
		end
	end

	assign out_tvalid      = m_tvalid_q;
	assign out_accepted    = m_acc_q;
	assign out_tempo_valid = m_valid_q;
	assign out_tempo_bpm   = m_bpm_q;

	a_valid_needs_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_valid_q |-> m_acc_q)
		else $error("tempo reported for a rejected press");

	a_bpm_zero_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !m_valid_q |-> m_bpm_q == '0)
		else $error("nonzero bpm without a valid tempo");

	a_bpm_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_valid_q |-> (m_bpm_q >= min_bpm) && (m_bpm_q <= max_bpm))
		else $error("reported bpm outside the configured range");

endmodule

FILE: rtl/core/tap_tempo_estimator_top.sv
// ----------------------------------------------------------------------------
// tap_tempo_estimator_top
// Tap tempo estimator: debounces presses and reports a tempo in bpm.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per button press, s_tdata holding the timer value
//   of the press. m_* returns one result per press: accepted flag, tempo valid
//   flag and tempo in bpm. cfg_* writes the five settings (debounce, match
//   tolerance, ticks per ms, min and max bpm); the user must do so while idle.
// Timing:
//   The front end registers a press, checks it and queues it before it takes
//   the next. A rejected or unmatched press goes from BK_IDLE to BK_OUT. A
//   matched set runs up to three divisions on one shared divider at 2 bits
//   per cycle: average (sum by 3), ms (by ticks per ms) and bpm (60000 by ms,
//   skipped if ms is zero), QW = TIME_BITS + 2 rounded up to even, then the
//   range check and the output load. The divider sets the rate.
// Reset:
//   All settings take their defaults, the interval ring and last press time
//   clear, and the first press after reset is never debounced.
// Stall:
//   A result waits in the output register; the two-entry queue keeps taking
//   presses until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
module tap_tempo_estimator_top import tte_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // [31:0] press_time
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata    // [0] press_accepted, [1] tempo_valid,
	                                            // [11:2] tempo_bpm, [15:12] zero
);

	localparam int SUM_BITS = TIME_BITS + 2;
	localparam int JOB_BITS = SUM_BITS + 2;

	logic [CFG_DATA_BITS-1:0] debounce_q;
	logic [CFG_DATA_BITS-1:0] tolerance_q;
	logic [TPM_BITS-1:0]      tpm_q;
	logic [BPM_BITS-1:0]      min_bpm_q;
	logic [BPM_BITS-1:0]      max_bpm_q;

	logic                push;
	tte_job_flags_t      push_flags;
	logic [SUM_BITS-1:0] push_sum;
	logic                pop;
	logic [JOB_BITS-1:0] q_rdata;
	logic                q_empty;
	logic                q_full;
	tte_job_flags_t      q_flags;
	logic [SUM_BITS-1:0] q_sum;

	logic                out_acc;
	logic                out_valid;
	logic [BPM_BITS-1:0] out_bpm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RST;
			tolerance_q <= TOLERANCE_RST;
			tpm_q       <= TPM_RST;
			min_bpm_q   <= MIN_BPM_RST;
			max_bpm_q   <= MAX_BPM_RST;
		end else if (cfg_we) begin
			case (tte_cfg_idx_t'(cfg_index))
				CFG_DEBOUNCE:  debounce_q  <= cfg_data;
				CFG_TOLERANCE: tolerance_q <= cfg_data;
				CFG_TPM:       tpm_q       <= cfg_data[TPM_BITS-1:0];
				CFG_MIN_BPM:   min_bpm_q   <= cfg_data[BPM_BITS-1:0];
				CFG_MAX_BPM:   max_bpm_q   <= cfg_data[BPM_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	tte_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_time     (s_tdata),
		.debounce    (debounce_q),
		.tolerance   (tolerance_q),
		.tpm_nonzero (tpm_q != '0),
		.full        (q_full),
		.push        (push),
		.push_flags  (push_flags),
		.push_sum    (push_sum)
	);

	tte_queue #(
		.WIDTH (JOB_BITS)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_sum, push_flags}),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	assign q_flags = tte_job_flags_t'(q_rdata[1:0]);
	assign q_sum   = q_rdata[JOB_BITS-1:2];

	tte_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_flags         (q_flags),
		.q_sum           (q_sum),
		.q_pop           (pop),
		.tpm             (tpm_q),
		.min_bpm         (min_bpm_q),
		.max_bpm         (max_bpm_q),
		.out_tvalid      (m_tvalid),
		.out_tready      (m_tready),
		.out_accepted    (out_acc),
		.out_tempo_valid (out_valid),
		.out_tempo_bpm   (out_bpm)
	);

	assign m_tdata = {{(OUT_DATA_BITS - BPM_BITS - 2){1'b0}}, out_bpm, out_valid, out_acc};

endmodule
